### sv/tsme_pkg.sv
// Shared types and constants of the trailed source model evaluator.
`timescale 1ns / 1ps
`default_nettype none

package tsme_pkg;

  // Default number of table intervals over zero to eight sigma.
  localparam int TSME_ERF_ENTRIES_DEF = 256;

  // Table values are Q.30 and never exceed 1.0, so 31 bits hold them.
  localparam int TAB_W = 31;
  localparam logic [63:0] QONE = 64'd1073741824;
  localparam logic [63:0] SIMPSON_GAIN = 64'd1142296032;

  // Offsets in sigma units are Q.16 below eight; one more bit marks saturation.
  localparam int U_QBITS = 19;
  localparam int U_BITS = U_QBITS + 1;

  // Rotated offsets and the numerators of the sigma-unit divisions.
  localparam int OFS_W = 37;
  localparam int U_NUM_W = OFS_W + 16;
  localparam int SIGMA_W = 24;
  localparam int LEN_W = 31;

  // Final scaling division: quotient saturates at 2^31.
  localparam int MAG_QBITS = 31;
  localparam int MAG_NUM_W = 65;
  localparam int MAG_DEN_W = LEN_W + 14;

  // Register stages from an accepted beat to its result strobe.
  localparam int TSME_LATENCY = 4 + (1 + U_QBITS) + 4 + 3 + (1 + MAG_QBITS) + 1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_CENTER_X       = 3'd0,
    REG_CENTER_Y       = 3'd1,
    REG_FLUX_AMPLITUDE = 3'd2,
    REG_TRAIL_LENGTH   = 3'd3,
    REG_COS_ANGLE      = 3'd4,
    REG_SIN_ANGLE      = 3'd5,
    REG_PSF_SIGMA      = 3'd6
  } reg_idx_t;

endpackage

`default_nettype wire

### sv/tsme_udiv.sv
// Pipelined restoring divider with a saturating quotient, one bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module tsme_udiv import tsme_pkg::*; #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 24,
  parameter int Q_BITS = 19,
  parameter int SB_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SB_W-1:0]   in_sb,
  output logic                   out_valid,
  output logic [Q_BITS:0]        out_quot,
  output logic [SB_W-1:0]        out_sb
);

  localparam int W = (NUM_W > DEN_W + Q_BITS) ? NUM_W : DEN_W + Q_BITS;

  logic [W-1:0]      rem  [0:Q_BITS];
  logic [DEN_W-1:0]  den  [0:Q_BITS];
  logic [Q_BITS-1:0] quot [0:Q_BITS];
  logic              sat  [0:Q_BITS];
  logic [SB_W-1:0]   sb   [0:Q_BITS];
  logic              vld  [0:Q_BITS];

  // Entry stage: a numerator at or above den * 2^Q_BITS saturates the quotient.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= W'(in_num);
    den[0]  <= in_den;
    quot[0] <= '0;
    sat[0]  <= W'(in_num) >= (W'(in_den) << Q_BITS);
    sb[0]   <= in_sb;
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s <= Q_BITS; s++) begin : g_step
    localparam int K = Q_BITS - s;
    logic [W-1:0] trial;
    logic         take;

    assign trial = W'(den[s-1]) << K;
    assign take  = rem[s-1] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= vld[s-1];
      end
      rem[s]     <= take ? rem[s-1] - trial : rem[s-1];
      quot[s]    <= quot[s-1] | (Q_BITS'(take) << K);
      den[s]     <= den[s-1];
      sat[s]     <= sat[s-1];
      sb[s]      <= sb[s-1];
    end
  end

  // A saturated quotient reads as exactly 2^Q_BITS.
  assign out_valid = vld[Q_BITS];
  assign out_sb    = sb[Q_BITS];
  assign out_quot  = sat[Q_BITS] ? ((Q_BITS + 1)'(1) << Q_BITS) : {1'b0, quot[Q_BITS]};

endmodule

`default_nettype wire

### sv/tsme_lookup.sv
// Interpolated lookup of the Gaussian or the error function table.
`timescale 1ns / 1ps
`default_nettype none

module tsme_lookup import tsme_pkg::*; #(
  parameter int ERF_TABLE_ENTRIES = TSME_ERF_ENTRIES_DEF,
  parameter bit IS_ERF = 1'b0,
  parameter int SB_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [U_BITS-1:0] in_u,
  input  wire logic [SB_W-1:0]   in_sb,
  output logic                   out_valid,
  output logic [TAB_W-1:0]       out_val,
  output logic [SB_W-1:0]        out_sb
);

  localparam int IW = $clog2(ERF_TABLE_ENTRIES + 1);
  localparam int P_W = U_QBITS + IW;

  typedef logic [ERF_TABLE_ENTRIES:0][TAB_W-1:0] tab_t;

  // exp(-x) in Q.30 by range halving, a short series and repeated squaring.
  function automatic logic [63:0] exp_neg(input logic [63:0] x);
    int unsigned        k;
    logic [63:0]        y;
    logic [63:0]        p;
    logic [63:0]        t;
    logic [63:0]        u;
    logic signed [63:0] r;
    k = 0;
    while (((x >> k) > (QONE >> 4)) && (k < 60)) begin
      k++;
    end
    y = x >> k;
    p = QONE;
    r = $signed(QONE);
    for (int n = 1; n <= 5; n++) begin
      p = (p * y) >> 30;
      case (n)
        1:       t = p;
        2:       t = p / 2;
        3:       t = p / 6;
        4:       t = p / 24;
        default: t = p / 120;
      endcase
      if ((n % 2) == 1) begin
        r = r - $signed(t);
      end else begin
        r = r + $signed(t);
      end
    end
    u = (r < 0) ? 64'd0 : 64'(r);
    for (int i = 0; i < k; i++) begin
      u = (u * u) >> 30;
    end
    return u;
  endfunction

  // Argument of the Gaussian at half-step j of the table grid.
  function automatic logic [63:0] half_step_arg(input logic [63:0] j);
    return ((j * j) << 33) / (ERF_TABLE_ENTRIES * ERF_TABLE_ENTRIES);
  endfunction

  // Gaussian samples, or their Simpson running integral clamped to 1.0.
  function automatic tab_t build_table();
    tab_t        tab;
    logic [63:0] acc;
    logic [63:0] g0;
    logic [63:0] gm;
    logic [63:0] g1;
    acc = 64'd0;
    g0 = exp_neg(64'd0);
    tab[0] = IS_ERF ? '0 : TAB_W'(g0);
    for (int i = 0; i < ERF_TABLE_ENTRIES; i++) begin
      gm = exp_neg(half_step_arg(64'(2 * i + 1)));
      g1 = exp_neg(half_step_arg(64'(2 * i + 2)));
      acc = acc + (((SIMPSON_GAIN * (g0 + 4 * gm + g1)) >> 30) / ERF_TABLE_ENTRIES);
      if (acc > QONE) begin
        acc = QONE;
      end
      tab[i + 1] = IS_ERF ? TAB_W'(acc) : TAB_W'(g1);
      g0 = g1;
    end
    return tab;
  endfunction

  localparam tab_t TABLE = build_table();

  logic [P_W-1:0]   pos;
  logic             v_a, v_b, v_c, v_d;
  logic [IW-1:0]    idx_lo, idx_hi;
  logic [15:0]      frac_a, frac_b;
  logic [TAB_W-1:0] val_lo, val_hi;
  logic [47:0]      prod_lo, prod_hi;
  logic [47:0]      sum;
  logic [SB_W-1:0]  sb_a, sb_b, sb_c, sb_d;

  assign pos = P_W'(in_u[U_QBITS-1:0]) * P_W'(ERF_TABLE_ENTRIES);
  assign sum = prod_lo + prod_hi;

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
    end else begin
      v_a <= in_valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
    end
  end

  // Index and fraction; at or beyond eight sigma both taps sit on the last entry.
  always_ff @(posedge clk) begin
    if (in_u[U_QBITS]) begin
      idx_lo <= IW'(ERF_TABLE_ENTRIES);
      idx_hi <= IW'(ERF_TABLE_ENTRIES);
      frac_a <= '0;
    end else begin
      idx_lo <= pos[P_W-1:U_QBITS];
      idx_hi <= pos[P_W-1:U_QBITS] + IW'(1);
      frac_a <= pos[U_QBITS-1:3];
    end
    sb_a <= in_sb;
  end

  // Table read, weighting and sum.
  always_ff @(posedge clk) begin
    val_lo  <= TABLE[idx_lo];
    val_hi  <= TABLE[idx_hi];
    frac_b  <= frac_a;
    sb_b    <= sb_a;
    prod_lo <= 48'(val_lo) * 48'(17'h10000 - {1'b0, frac_b});
    prod_hi <= 48'(val_hi) * 48'(frac_b);
    sb_c    <= sb_b;
    out_val <= sum[46:16];
    sb_d    <= sb_c;
  end

  assign out_valid = v_d;
  assign out_sb    = sb_d;

endmodule

`default_nettype wire

### sv/trailed_source_model_eval_unit.sv
// Top level of the trailed source model evaluator.
//
// One pixel coordinate (pixel_x, pixel_y) is accepted at each rising edge
// where start is high and busy is low; busy is high only during reset.
// For every accepted beat one model_value appears, in order, marked by
// done for a single cycle. Throughput is one pixel per cycle: every unit
// is fully pipelined. The latency comes mostly from the three parallel
// 20-stage dividers into sigma units and the 32-stage divider that
// scales by flux over length.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data with
// no wait; the user must make writes go in only while no pixel is in
// flight, which the block itself does not enforce. An index beyond the
// register list is ignored. Reset returns the registers to their defaults
// and drops every beat in flight. The receiver cannot stall; a result is
// on the ports for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module trailed_source_model_eval_unit import tsme_pkg::*; #(
  parameter int ERF_TABLE_ENTRIES = TSME_ERF_ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] pixel_x,
  input  wire logic signed [15:0] pixel_y,
  output logic                    done,
  output logic signed [31:0]      model_value,
  input  wire logic               cfg_wr_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic signed [31:0]  center_x, center_y, flux_amplitude;
  logic [LEN_W-1:0]    trail_length;
  logic signed [15:0]  cos_angle, sin_angle;
  logic [SIGMA_W-1:0]  psf_sigma;
  logic [SIGMA_W-1:0]  sigma_eff;
  logic [LEN_W-1:0]    len_eff;

  logic                v1, v2, v3, v4, vd, vm, vn, vo;
  logic signed [32:0]  dx, dy;
  logic signed [48:0]  p_xc, p_ys, p_xs, p_yc;
  logic signed [49:0]  rot_x, rot_y;
  logic signed [35:0]  xp, yp;
  logic signed [OFS_W-1:0] half, xp_ext, yp_ext, w_a, w_b;
  logic [OFS_W-1:0]    y_mag, a_mag, b_mag;
  logic                a_sign, b_sign;

  logic                du_valid;
  logic [U_BITS-1:0]   u_y, u_a, u_b;
  logic                du_sb_a, du_sb_b;
  logic                lk_valid;
  logic [TAB_W-1:0]    g_val, ea_val, eb_val;
  logic                lk_sb_a, lk_sb_b;

  logic signed [32:0]  ea_s, eb_s, diff;
  logic [TAB_W-1:0]    g_d;
  logic [31:0]         diff_mag;
  logic                diff_neg, neg_m, neg_n;
  logic [62:0]         gm_prod;
  logic [31:0]         m_val;
  logic [31:0]         flux_mag;
  logic [63:0]         n_val;

  logic                dm_valid, dm_neg;
  logic [MAG_QBITS:0]  q_mag;
  logic signed [31:0]  result_next;

  assign busy = rst;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      flux_amplitude <= '0;
      trail_length   <= LEN_W'(65536);
      cos_angle      <= 16'sd16384;
      sin_angle      <= '0;
      psf_sigma      <= SIGMA_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CENTER_X:       center_x       <= $signed(cfg_data);
        REG_CENTER_Y:       center_y       <= $signed(cfg_data);
        REG_FLUX_AMPLITUDE: flux_amplitude <= $signed(cfg_data);
        REG_TRAIL_LENGTH:   trail_length   <= cfg_data[LEN_W-1:0];
        REG_COS_ANGLE:      cos_angle      <= $signed(cfg_data[15:0]);
        REG_SIN_ANGLE:      sin_angle      <= $signed(cfg_data[15:0]);
        REG_PSF_SIGMA:      psf_sigma      <= cfg_data[SIGMA_W-1:0];
        default:            ;
      endcase
    end
  end

  // A zero sigma or length acts as the smallest step.
  assign sigma_eff = (psf_sigma == '0) ? SIGMA_W'(1) : psf_sigma;
  assign len_eff   = (trail_length == '0) ? LEN_W'(1) : trail_length;

  // Valid bits of the front and back stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vd <= 1'b0;
      vm <= 1'b0;
      vn <= 1'b0;
      vo <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vd <= lk_valid;
      vm <= vd;
      vn <= vm;
      vo <= dm_valid;
    end
  end

  // Offset from the trail centre, then the four rotation products.
  always_ff @(posedge clk) begin
    dx   <= $signed({pixel_x[15], pixel_x, 16'h0000}) - $signed({center_x[31], center_x});
    dy   <= $signed({pixel_y[15], pixel_y, 16'h0000}) - $signed({center_y[31], center_y});
    p_xc <= dx * cos_angle;
    p_ys <= dy * sin_angle;
    p_xs <= dx * sin_angle;
    p_yc <= dy * cos_angle;
  end

  // Rotated offsets, floored from Q.30 to Q.16.
  assign rot_x = $signed({p_xc[48], p_xc}) - $signed({p_ys[48], p_ys});
  assign rot_y = $signed({p_xs[48], p_xs}) + $signed({p_yc[48], p_yc});

  always_ff @(posedge clk) begin
    xp <= rot_x[49:14];
    yp <= rot_y[49:14];
  end

  // Erf arguments at both trail ends, and all three magnitudes.
  assign half   = $signed({7'b0, trail_length[LEN_W-1:1]});
  assign xp_ext = $signed({xp[35], xp});
  assign yp_ext = $signed({yp[35], yp});
  assign w_a    = xp_ext + half;
  assign w_b    = xp_ext - half;

  always_ff @(posedge clk) begin
    y_mag  <= yp_ext[OFS_W-1] ? OFS_W'(-yp_ext) : OFS_W'(yp_ext);
    a_mag  <= w_a[OFS_W-1] ? OFS_W'(-w_a) : OFS_W'(w_a);
    b_mag  <= w_b[OFS_W-1] ? OFS_W'(-w_b) : OFS_W'(w_b);
    a_sign <= w_a[OFS_W-1];
    b_sign <= w_b[OFS_W-1];
  end

  // Three lanes into sigma units.
  tsme_udiv #(
    .NUM_W(U_NUM_W), .DEN_W(SIGMA_W), .Q_BITS(U_QBITS), .SB_W(1)
  ) u_div_y (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num({y_mag, 16'h0000}),
    .in_den(sigma_eff), .in_sb(1'b0),
    .out_valid(du_valid), .out_quot(u_y), .out_sb()
  );

  tsme_udiv #(
    .NUM_W(U_NUM_W), .DEN_W(SIGMA_W), .Q_BITS(U_QBITS), .SB_W(1)
  ) u_div_a (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num({a_mag, 16'h0000}),
    .in_den(sigma_eff), .in_sb(a_sign),
    .out_valid(), .out_quot(u_a), .out_sb(du_sb_a)
  );

  tsme_udiv #(
    .NUM_W(U_NUM_W), .DEN_W(SIGMA_W), .Q_BITS(U_QBITS), .SB_W(1)
  ) u_div_b (
    .clk(clk), .rst(rst), .in_valid(v4), .in_num({b_mag, 16'h0000}),
    .in_den(sigma_eff), .in_sb(b_sign),
    .out_valid(), .out_quot(u_b), .out_sb(du_sb_b)
  );

  // Across-trail Gaussian and the two along-trail erf values.
  tsme_lookup #(
    .ERF_TABLE_ENTRIES(ERF_TABLE_ENTRIES), .IS_ERF(1'b0), .SB_W(1)
  ) u_lk_gauss (
    .clk(clk), .rst(rst), .in_valid(du_valid), .in_u(u_y), .in_sb(1'b0),
    .out_valid(lk_valid), .out_val(g_val), .out_sb()
  );

  tsme_lookup #(
    .ERF_TABLE_ENTRIES(ERF_TABLE_ENTRIES), .IS_ERF(1'b1), .SB_W(1)
  ) u_lk_erf_a (
    .clk(clk), .rst(rst), .in_valid(du_valid), .in_u(u_a), .in_sb(du_sb_a),
    .out_valid(), .out_val(ea_val), .out_sb(lk_sb_a)
  );

  tsme_lookup #(
    .ERF_TABLE_ENTRIES(ERF_TABLE_ENTRIES), .IS_ERF(1'b1), .SB_W(1)
  ) u_lk_erf_b (
    .clk(clk), .rst(rst), .in_valid(du_valid), .in_u(u_b), .in_sb(du_sb_b),
    .out_valid(), .out_val(eb_val), .out_sb(lk_sb_b)
  );

  // Signed erf difference.
  assign ea_s = lk_sb_a ? -$signed({2'b00, ea_val}) : $signed({2'b00, ea_val});
  assign eb_s = lk_sb_b ? -$signed({2'b00, eb_val}) : $signed({2'b00, eb_val});
  assign diff = ea_s - eb_s;

  always_ff @(posedge clk) begin
    g_d      <= g_val;
    diff_mag <= diff[32] ? 32'(-diff) : 32'(diff);
    diff_neg <= diff[32];
  end

  // Gaussian times erf difference, then times the flux magnitude.
  assign gm_prod  = 63'(g_d) * 63'(diff_mag);
  assign flux_mag = flux_amplitude[31] ? 32'(-flux_amplitude) : 32'(flux_amplitude);

  always_ff @(posedge clk) begin
    m_val <= gm_prod[61:30];
    neg_m <= diff_neg;
    n_val <= 64'(flux_mag) * 64'(m_val);
    neg_n <= neg_m ^ flux_amplitude[31];
  end

  // Division by the length in Q.30, saturating at 2^31.
  tsme_udiv #(
    .NUM_W(MAG_NUM_W), .DEN_W(MAG_DEN_W), .Q_BITS(MAG_QBITS), .SB_W(1)
  ) u_div_mag (
    .clk(clk), .rst(rst), .in_valid(vn), .in_num({n_val, 1'b0}),
    .in_den({len_eff, 14'h0000}), .in_sb(neg_n),
    .out_valid(dm_valid), .out_quot(q_mag), .out_sb(dm_neg)
  );

  // Sign and saturation to Q16.16.
  always_comb begin
    if (dm_neg) begin
      result_next = $signed(32'd0 - q_mag[31:0]);
    end else if (q_mag[MAG_QBITS]) begin
      result_next = 32'sh7FFFFFFF;
    end else begin
      result_next = $signed(q_mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    model_value <= result_next;
  end

  assign done = vo;

endmodule

`default_nettype wire

### sv/tsme_port_checker.sv
// Port-level checks of the evaluator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tsme_port_checker import tsme_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  localparam int CW = $clog2(TSME_LATENCY + 1);

  logic [CW-1:0] since_rst;

  // Cycles since the last reset, held once the pipeline has filled.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CW'(TSME_LATENCY)) begin
      since_rst <= since_rst + CW'(1);
    end
  end

  // Every result traces back to a beat accepted a fixed latency earlier.
  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TSME_LATENCY))
    else $error("result without an accepted beat");

  // A beat accepted after reset always yields its result on time.
  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (since_rst == CW'(TSME_LATENCY)) && $past(start && !busy, TSME_LATENCY) |-> done)
    else $error("accepted beat produced no result");

  // Reset drops every beat in flight.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule

bind trailed_source_model_eval_unit tsme_port_checker u_port_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .done(done)
);

`default_nettype wire
